/* src/smvs_pkg.sv */
// ----------------------------------------------------------------------------
// smvs_pkg
// shared widths, codes and types of the slotted minimum-value selector
// ----------------------------------------------------------------------------
package smvs_pkg;

  localparam int SLOTS    = 16;
  localparam int VALUE_W  = 64;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  // bits that index the occupancy vector
  localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  // one entry of the sorted chain
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [SLOT_W-1:0]  key_slot;
    logic [VALUE_W-1:0] key_value;
  } cell_ctrl_t;

endpackage

/* src/smvs_if.sv */
// ----------------------------------------------------------------------------
// smvs_req_if / smvs_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface smvs_req_if;
  logic                       valid;
  logic                       ready;
  smvs_pkg::kind_t            kind;
  logic [smvs_pkg::SLOT_W-1:0]  slot;
  logic [smvs_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, slot, value, input ready);
  modport sink   (input valid, kind, slot, value, output ready);
endinterface

interface smvs_rsp_if;
  logic                        valid;
  logic                        ready;
  smvs_pkg::status_t           status;
  logic [smvs_pkg::SLOT_W-1:0] popped_slot;

  modport source (output valid, status, popped_slot, input ready);
  modport sink   (input valid, status, popped_slot, output ready);
endinterface

/* src/smvs_cell.sv */
// ----------------------------------------------------------------------------
// smvs_cell
// one position of the sorted chain: compare with the key, shift or hold
// ----------------------------------------------------------------------------
module smvs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  smvs_pkg::cell_ctrl_t ctrl,
  input  smvs_pkg::entry_t     left,
  input  logic                 left_gt,
  input  smvs_pkg::entry_t     right,
  output smvs_pkg::entry_t     cur,
  output logic                 gt
);

  smvs_pkg::entry_t cur_next;
  logic             key_less;

  // key ordering: value first, then slot index
  assign key_less = (ctrl.key_value < cur.value) ||
                    ((ctrl.key_value == cur.value) && (ctrl.key_slot < cur.slot));
  assign gt = !cur.valid || key_less;

  always_comb begin
    cur_next = cur;
    if (ctrl.pop) begin
      cur_next = right;
    end else if (ctrl.push && gt) begin
      if (left_gt) begin
        cur_next = left;
      end else begin
        cur_next.valid = 1'b1;
        cur_next.slot  = ctrl.key_slot;
        cur_next.value = ctrl.key_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur.slot  <= cur_next.slot;
    cur.value <= cur_next.value;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end

endmodule

/* src/slotted_min_value_selector_unit.sv */
// ----------------------------------------------------------------------------
// slotted_min_value_selector_unit
// keeps occupied slots in a chain sorted by value and pops the smallest
// ----------------------------------------------------------------------------
// result: lands in the output register in the cycle after the request transfer
// throughput: one item per cycle while results are taken; set by the single
//   compare-and-shift step of each cell in the sorted chain
// reset: the chain empties and every slot is marked free,
//   stored values are left as they are
module slotted_min_value_selector_unit (
  input  logic      clk,
  input  logic      rst,
  smvs_req_if.sink  req,
  smvs_rsp_if.source rsp
);

  // chain state, head at index zero holds the smallest key
  smvs_pkg::entry_t           chain_q  [smvs_pkg::SLOTS];
  logic [smvs_pkg::SLOTS-1:0] chain_gt;
  smvs_pkg::cell_ctrl_t       ctrl;

  // one flag per slot, cleared by reset
  logic [smvs_pkg::SLOTS-1:0] slot_occupied;
  logic [smvs_pkg::SLOTS-1:0] slot_occupied_next;

  logic                       accept;
  logic                       out_of_range;
  logic                       busy;
  smvs_pkg::status_t          status_next;
  logic [smvs_pkg::SLOT_W-1:0] popped_next;

  // the output register frees as its result is taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign out_of_range = {1'b0, req.slot} >= (smvs_pkg::SLOT_W + 1)'(smvs_pkg::SLOTS);
  assign busy         = slot_occupied[req.slot[smvs_pkg::SLOT_IW-1:0]];

  always_comb begin
    ctrl.push          = 1'b0;
    ctrl.pop           = 1'b0;
    ctrl.key_slot      = req.slot;
    ctrl.key_value     = req.value;
    slot_occupied_next = slot_occupied;
    status_next        = smvs_pkg::ST_OK;
    popped_next        = '0;
    if (req.kind == smvs_pkg::KIND_PUSH) begin
      if (out_of_range) begin
        status_next = smvs_pkg::ST_RANGE;
      end else if (busy) begin
        status_next = smvs_pkg::ST_BUSY;
      end else begin
        // insert into the chain and claim the slot
        ctrl.push = accept;
        if (accept) begin
          slot_occupied_next[req.slot[smvs_pkg::SLOT_IW-1:0]] = 1'b1;
        end
      end
    end else begin
      if (chain_q[0].valid) begin
        // head leaves, the rest of the chain moves up one place
        ctrl.pop    = accept;
        popped_next = chain_q[0].slot;
        if (accept) begin
          slot_occupied_next[chain_q[0].slot[smvs_pkg::SLOT_IW-1:0]] = 1'b0;
        end
      end else begin
        status_next = smvs_pkg::ST_EMPTY;
      end
    end
  end

  // row of cells, each hands its entry to a neighbour on a shift
  for (genvar i = 0; i < smvs_pkg::SLOTS; i++) begin : g_cell
    smvs_pkg::entry_t left_e;
    smvs_pkg::entry_t right_e;
    logic             left_gt;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_e  = chain_q[i-1];
      assign left_gt = chain_gt[i-1];
    end

    if (i == smvs_pkg::SLOTS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = chain_q[i+1];
    end

    smvs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .left    (left_e),
      .left_gt (left_gt),
      .right   (right_e),
      .cur     (chain_q[i]),
      .gt      (chain_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_occupied <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      slot_occupied <= slot_occupied_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each request transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status_next;
      rsp.popped_slot <= popped_next;
    end
  end

endmodule

/* src/smvs_checker.sv */
// ----------------------------------------------------------------------------
// smvs_checker
// port-level checks of the slotted minimum-value selector
// ----------------------------------------------------------------------------
module smvs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input smvs_pkg::kind_t             req_kind,
  input logic [smvs_pkg::SLOT_W-1:0] req_slot,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input smvs_pkg::status_t           rsp_status,
  input logic [smvs_pkg::SLOT_W-1:0] rsp_popped_slot
);

  logic req_xfer;
  assign req_xfer = req_valid && req_ready;

  // no result straight out of reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown straight after reset");

  // only a successful pop names a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != smvs_pkg::ST_OK) |-> rsp_popped_slot == '0)
    else $error("slot reported with a failing status");

  // nothing is stored right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && req_xfer && req_kind == smvs_pkg::KIND_POP) |=>
      (rsp_valid && rsp_status == smvs_pkg::ST_EMPTY))
    else $error("pop after reset found an entry");

  // push beyond the slot count is refused
  a_range: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req_kind == smvs_pkg::KIND_PUSH &&
     {1'b0, req_slot} >= (smvs_pkg::SLOT_W + 1)'(smvs_pkg::SLOTS)) |=>
      (rsp_valid && rsp_status == smvs_pkg::ST_RANGE))
    else $error("out of range push not refused");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_popped_slot)))
    else $error("stalled result changed");

endmodule

bind slotted_min_value_selector_unit smvs_checker u_smvs_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_kind        (req.kind),
  .req_slot        (req.slot),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_popped_slot (rsp.popped_slot)
);

/* dv/smvs_result_checker.sv */
// ----------------------------------------------------------------------------
// smvs_result_checker
// follows request and result transfers on the selector's two channels,
// keeps its own copy of slot values and occupancy, and compares each
// result with the one its own prediction gives for the matching request
// ----------------------------------------------------------------------------
module smvs_result_checker (
  input  logic clk,
  input  logic rst,
  smvs_req_if  req,
  smvs_rsp_if  rsp,
  output int   error_count,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import smvs_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] popped_slot;
  } selection_t;

  selection_t         owed_selections[$];
  logic [VALUE_W-1:0] slot_value_copy[SLOTS];
  logic [SLOTS-1:0]   slot_taken;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // applies one request to the local slot state and gives the result it owes
  function automatic selection_t predict_selection(kind_t kind, logic [SLOT_W-1:0] slot,
                                                   logic [VALUE_W-1:0] value);
    selection_t sel;
    int         best;
    sel.status      = ST_OK;
    sel.popped_slot = '0;
    best            = -1;
    if (kind == KIND_PUSH) begin
      if (slot >= SLOTS) begin
        sel.status = ST_RANGE;
      end else if (slot_taken[slot]) begin
        sel.status = ST_BUSY;
      end else begin
        slot_value_copy[slot] = value;
        slot_taken[slot]      = 1'b1;
      end
    end else begin
      // strict less-than keeps the lowest index among equal values
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_taken[s] && (best < 0 || slot_value_copy[s] < slot_value_copy[best])) begin
          best = s;
        end
      end
      if (best < 0) begin
        sel.status = ST_EMPTY;
      end else begin
        slot_taken[best] = 1'b0;
        sel.popped_slot  = SLOT_W'(best);
      end
    end
    return sel;
  endfunction

  initial begin
    error_count  = 0;
    results_owed = 0;
    slot_taken   = '0;
  end

  always @(posedge clk) begin
    selection_t want;
    if (rst) begin
      slot_taken = '0;
      owed_selections.delete();
    end else begin
      // a result transfer always belongs to an earlier request, so check it first
      if (rsp.valid && rsp.ready) begin
        if (owed_selections.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: status %0d slot %0d",
                                    rsp.status, rsp.popped_slot));
        end else begin
          want = owed_selections.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", rsp.status, want.status));
          if (rsp.popped_slot !== want.popped_slot)
            report_mismatch($sformatf("popped_slot %0d, predicted %0d",
                                      rsp.popped_slot, want.popped_slot));
        end
      end
      if (req.valid && req.ready)
        owed_selections.push_back(predict_selection(req.kind, req.slot, req.value));
    end
    results_owed = owed_selections.size();
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives pushes and pops into the slotted minimum-value selector with
// bursty requests and a stalling result side; a checker beside the block
// predicts every result, and this module gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smvs_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int SETTLE_CYCLES = 4;

  // result-side ready patterns, picked at random during the run
  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_PULSE,
    RX_SPARSE
  } rx_mode_t;

  logic     clk;
  logic     rst;
  int       error_count;
  int       results_owed;
  int       idle_cycles;
  int       rx_cycle;
  rx_mode_t rx_mode;

  smvs_req_if req_ch ();
  smvs_rsp_if rsp_ch ();

  slotted_min_value_selector_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  smvs_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // one request transfer; entered and left at a falling edge, valid left high
  task automatic transfer_item(kind_t kind, logic [SLOT_W-1:0] slot,
                               logic [VALUE_W-1:0] value);
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.slot  <= slot;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // pop fields other than kind are ignored, so fill them with noise
  task automatic pop_item();
    transfer_item(KIND_POP, SLOT_W'($urandom), {$urandom, $urandom});
  endtask

  // ordering values: a spread over the full range, a tiny pool that makes ties,
  // and the corners of the unsigned range
  function automatic logic [VALUE_W-1:0] pick_ordering_value();
    case ($urandom_range(0, 4))
      0, 1:    return {$urandom, $urandom};
      2:       return VALUE_W'($urandom_range(0, 3));
      3:       return {32'hFFFF_FFFF, $urandom};
      default: begin
        case ($urandom_range(0, 2))
          0:       return '1;
          1:       return '0;
          default: return 64'h8000_0000_0000_0000;
        endcase
      end
    endcase
  endfunction

  // receiver side: ready changes on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_cycle     <= 0;
      rx_mode      <= RX_FLOW;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 63)
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FLOW:   rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
        RX_PULSE:  rsp_ch.ready <= (rx_cycle % 7) < 2;
        default:   rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog: any transfer restarts the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int push_pct;
    int burst_len;
    int gap;
    int phase_count;
    bit gapless;
    logic [SLOT_W-1:0] slot;

    clk          = 1'b0;
    rst          = 1'b1;
    idle_cycles  = 0;
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_PUSH;
    req_ch.slot  = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    pop_item();                                         // nothing to pop yet
    transfer_item(KIND_PUSH, 8'd0, '1);                 // all-ones is an ordinary value
    transfer_item(KIND_PUSH, 8'd15, '0);                // top slot, smallest value
    transfer_item(KIND_PUSH, 8'd16, {$urandom, $urandom}); // first index out of range
    transfer_item(KIND_PUSH, 8'd255, '0);               // every slot bit high
    transfer_item(KIND_PUSH, 8'd128, '1);
    transfer_item(KIND_PUSH, 8'd0, 64'd5);              // slot 0 already taken
    transfer_item(KIND_PUSH, 8'd7, '0);                 // ties with slot 15
    pop_item();                                         // tie goes to slot 7
    pop_item();                                         // then slot 15
    transfer_item(KIND_PUSH, 8'd8, 64'h8000_0000_0000_0000);
    transfer_item(KIND_PUSH, 8'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    transfer_item(KIND_PUSH, 8'd3, 64'h7FFF_FFFF_FFFF_FFFF); // tie above slot 1
    pop_item();
    pop_item();
    pop_item();
    pop_item();                                         // slot 0 holding all-ones
    pop_item();                                         // empty again

    // random part: phases with their own push/pop balance so the slots
    // fill up, drain and churn; some phases send with no gaps at all
    for (int phase = 0; phase < PHASES; phase++) begin
      push_pct    = $urandom_range(20, 90);
      gapless     = ($urandom_range(0, 3) == 0);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        burst_len = $urandom_range(1, 12);
        for (int n = 0; n < burst_len; n++) begin
          if ($urandom_range(1, 100) <= push_pct) begin
            // mostly real slots, some indexes past the end
            if ($urandom_range(0, 9) == 0)
              slot = SLOT_W'($urandom_range(SLOTS, 255));
            else
              slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            transfer_item(KIND_PUSH, slot, pick_ordering_value());
          end else begin
            pop_item();
          end
        end
        phase_count += burst_len;
        gap = gapless ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          req_ch.valid <= 1'b0;
          req_ch.slot  <= SLOT_W'($urandom);
          req_ch.value <= {$urandom, $urandom};
          repeat (gap) @(negedge clk);
        end
      end
    end
    req_ch.valid <= 1'b0;

    // drain outstanding results, then give the block time to misbehave
    wait (results_owed == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
